FILE: rtl/elu_pkg.sv
// ============================================================================
// elu_pkg
// Shared types, codes and character classes for the expression lexer.
// ============================================================================
package elu_pkg;

    localparam int ELU_VALUE_BITS = 32;
    localparam int IN_BITS        = 8;
    localparam int OUT_BITS       = 112;

    // scanner modes
    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_OPPEND = 3'd1,
        M_SYM    = 3'd2,
        M_INT    = 3'd3,
        M_REAL   = 3'd4,
        M_STR    = 3'd5,
        M_OTHER  = 3'd6
    } mode_t;

    // token kinds
    localparam logic [2:0] KIND_SYMBOL   = 3'd0;
    localparam logic [2:0] KIND_INTEGER  = 3'd1;
    localparam logic [2:0] KIND_REAL     = 3'd2;
    localparam logic [2:0] KIND_OPERATOR = 3'd3;
    localparam logic [2:0] KIND_STRING   = 3'd4;
    localparam logic [2:0] KIND_VAR      = 3'd5;
    localparam logic [2:0] KIND_UNTERM   = 3'd6;

    typedef enum logic [4:0] {
        OP_PLUS, OP_MINUS, OP_MULT, OP_DIV, OP_MOD, OP_POW, OP_AND, OP_OR,
        OP_NOT, OP_XOR, OP_GT, OP_LT, OP_GTE, OP_LTE, OP_EQ, OP_NEQ,
        OP_LPAREN, OP_RPAREN, OP_ERROR, OP_ESCAPE, OP_ASSIGN, OP_LCURL,
        OP_RCURL, OP_COMMA, OP_VAR, OP_LBRACKET, OP_RBRACKET, OP_CONSTRAINT,
        OP_COND, OP_ELSE
    } op_t;

    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_USCORE = "_";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_TILDE  = "~";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_LT     = "<";

    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] start;
        logic [7:0]  fdig;
        logic [31:0] frac;
        logic [31:0] ival;
        logic [4:0]  op;
        logic [2:0]  kind;
    } tok_t;

    typedef struct packed {
        logic       is_op;
        logic [4:0] code;
    } op_hit_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // operator code of first byte c, paired with nx where a pair applies
    function automatic op_hit_t op_lookup(input logic [7:0] c, input logic [7:0] nx);
        op_hit_t r;
        r.is_op = 1'b1;
        r.code  = OP_PLUS;
        case (c)
            "+":  r.code = OP_PLUS;
            "-":  r.code = OP_MINUS;
            "*":  r.code = (nx == CH_STAR) ? OP_POW : OP_MULT;
            "/":  r.code = OP_DIV;
            "%":  r.code = OP_MOD;
            "&":  r.code = OP_AND;
            "|":  r.code = OP_OR;
            "~":  r.code = (nx == CH_EQ) ? OP_NEQ : OP_NOT;
            "^":  r.code = OP_XOR;
            ">":  r.code = (nx == CH_EQ) ? OP_GTE : OP_GT;
            "<":  r.code = (nx == CH_EQ) ? OP_LTE : OP_LT;
            "=":  r.code = (nx == CH_EQ) ? OP_EQ : OP_ASSIGN;
            "(":  r.code = OP_LPAREN;
            ")":  r.code = OP_RPAREN;
            "{":  r.code = OP_LCURL;
            "}":  r.code = OP_RCURL;
            "\\": r.code = OP_ESCAPE;
            ",":  r.code = OP_COMMA;
            "[":  r.code = OP_LBRACKET;
            "]":  r.code = OP_RBRACKET;
            "?":  r.code = OP_COND;
            ":":  r.code = OP_ELSE;
            "@":  r.code = OP_CONSTRAINT;
            default: r.is_op = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/expression_lexer_unit.sv
// ============================================================================
// expression_lexer_unit
// Streaming tokenizer: one text byte per beat in, closed tokens out.
// ============================================================================
//  channel  | dir | tdata                          | tlast        | tuser
//  s_axis   | in  | ch[7:0]                        | end_of_text  | -
//  m_axis   | out | kind,op,int,frac,fdig,col,len  | last         | -
//
//  One input beat per cycle; its tokens are computed in the same cycle from
//  the scanner registers and land in a four-entry result queue.
//  A byte yields zero, one or two tokens; input stalls while fewer than two
//  queue entries are free, so the rate is one byte per cycle unless tokens
//  pile up faster than m_axis drains them.
//  Reset clears the scanner mode, counters and the queue.
// ============================================================================
module expression_lexer_unit #(
    parameter int VALUE_BITS = elu_pkg::ELU_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [elu_pkg::IN_BITS-1:0]   s_axis_tdata,   // ch[7:0]
    input  logic                          s_axis_tlast,   // end_of_text
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // token_kind[2:0], op_code[7:3], int_value[39:8], frac_value[71:40],
    // frac_digits[79:72], start_col[95:80], token_length[111:96]
    output logic [elu_pkg::OUT_BITS-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast    // last
);
    import elu_pkg::*;

    localparam int QDEPTH = 4;

    mode_t                 mode_reg, mode_next;
    logic [7:0]            pend_reg, pend_next;
    logic [VALUE_BITS-1:0] int_acc_reg, int_acc_next;
    logic [VALUE_BITS-1:0] frac_acc_reg, frac_acc_next;
    logic [7:0]            frac_cnt_reg, frac_cnt_next;
    logic [15:0]           column_reg, column_next;
    logic [15:0]           tstart_reg, tstart_next;
    logic [15:0]           tlen_reg, tlen_next;

    tok_t                  queue_reg [QDEPTH];
    logic [1:0]            wr_ptr_reg, wr_ptr_next;
    logic [1:0]            rd_ptr_reg, rd_ptr_next;
    logic [2:0]            count_reg, count_next;

    logic       s_fire, m_fire;
    logic [7:0] ch;
    tok_t       fl_tok, st_tok, res0, res1;
    logic       fl_valid;
    logic       st_emit;
    mode_t      st_mode;
    op_hit_t    st_op;
    op_hit_t    fl_op, pair_op;
    logic       do_close, do_start;
    logic [1:0] n_push;
    logic [15:0] len_inc;

    function automatic logic [VALUE_BITS-1:0] acc_digit(input logic [VALUE_BITS-1:0] acc,
                                                        input logic [3:0] d);
        logic [VALUE_BITS+3:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_BITS+4)'(d);
        if (wide > {4'b0, {VALUE_BITS{1'b1}}})
            return '1;
        return wide[VALUE_BITS-1:0];
    endfunction

    assign ch            = s_axis_tdata;
    assign s_axis_tready = (count_reg <= 3'(QDEPTH - 2));
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign len_inc       = (tlen_reg == 16'hFFFF) ? tlen_reg : tlen_reg + 16'd1;
    assign fl_op         = op_lookup(pend_reg, 8'd0);
    assign pair_op       = op_lookup(pend_reg, ch);

    // pending token as it stands if the text ended now
    always_comb
    begin
        fl_tok        = '0;
        fl_tok.start  = tstart_reg;
        fl_tok.length = tlen_reg;
        fl_valid      = 1'b1;
        case (mode_reg)
            M_OPPEND:
            begin
                fl_tok.kind   = KIND_OPERATOR;
                fl_tok.op     = fl_op.code;
                fl_tok.length = 16'd1;
            end
            M_SYM, M_OTHER: fl_tok.kind = KIND_SYMBOL;
            M_INT:
            begin
                fl_tok.kind = KIND_INTEGER;
                fl_tok.ival = 32'(int_acc_reg);
            end
            M_REAL:
            begin
                fl_tok.kind = KIND_REAL;
                fl_tok.ival = 32'(int_acc_reg);
                fl_tok.frac = 32'(frac_acc_reg);
                fl_tok.fdig = frac_cnt_reg;
            end
            M_STR: fl_tok.kind = KIND_UNTERM;
            default: fl_valid = 1'b0;
        endcase
    end

    // token opened by the current byte
    always_comb
    begin
        st_op        = op_lookup(ch, 8'd0);
        st_tok       = '0;
        st_tok.start = column_reg;
        st_tok.length = 16'd1;
        st_emit      = 1'b0;
        st_mode      = M_IDLE;
        if (is_ws(ch))
        begin
            st_mode = M_IDLE;
        end
        else if (st_op.is_op)
        begin
            if (ch == CH_STAR || ch == CH_TILDE || ch == CH_GT || ch == CH_LT ||
                ch == CH_EQ)
            begin
                st_mode = M_OPPEND;
            end
            else
            begin
                st_emit     = 1'b1;
                st_tok.kind = KIND_OPERATOR;
                st_tok.op   = st_op.code;
            end
        end
        else if (ch == CH_DOLLAR)
        begin
            st_emit     = 1'b1;
            st_tok.kind = KIND_VAR;
            st_tok.op   = OP_VAR;
        end
        else if (is_alpha(ch))
            st_mode = M_SYM;
        else if (is_digit(ch))
            st_mode = M_INT;
        else if (ch == CH_QUOTE)
            st_mode = M_STR;
        else
            st_mode = M_OTHER;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        pend_next     = pend_reg;
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        column_next   = column_reg;
        tstart_next   = tstart_reg;
        tlen_next     = tlen_reg;
        do_close      = 1'b0;
        do_start      = 1'b0;
        res0          = '0;
        res1          = '0;
        n_push        = 2'd0;

        if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                if (fl_valid)
                begin
                    res0      = fl_tok;
                    res0.last = 1'b1;
                    n_push    = 2'd1;
                end
                mode_next     = M_IDLE;
                pend_next     = '0;
                int_acc_next  = '0;
                frac_acc_next = '0;
                frac_cnt_next = '0;
                tstart_next   = '0;
                tlen_next     = '0;
                column_next   = '0;
            end
            else
            begin
                column_next = column_reg + 16'd1;
                case (mode_reg)
                    M_OPPEND:
                    begin
                        if ((pend_reg == CH_STAR && ch == CH_STAR) ||
                            (pend_reg != CH_STAR && ch == CH_EQ))
                        begin
                            res0.kind   = KIND_OPERATOR;
                            res0.op     = pair_op.code;
                            res0.start  = tstart_reg;
                            res0.length = 16'd2;
                            res0.last   = 1'b1;
                            n_push      = 2'd1;
                            mode_next   = M_IDLE;
                        end
                        else
                            do_close = 1'b1;
                    end
                    M_SYM:
                    begin
                        if (is_alpha(ch) || ch == CH_USCORE)
                            tlen_next = len_inc;
                        else
                            do_close = 1'b1;
                    end
                    M_INT:
                    begin
                        if (is_digit(ch))
                        begin
                            int_acc_next = acc_digit(int_acc_reg, ch[3:0]);
                            tlen_next    = len_inc;
                        end
                        else if (ch == CH_DOT)
                        begin
                            mode_next = M_REAL;
                            tlen_next = len_inc;
                        end
                        else
                            do_close = 1'b1;
                    end
                    M_REAL:
                    begin
                        if (is_digit(ch))
                        begin
                            frac_acc_next = acc_digit(frac_acc_reg, ch[3:0]);
                            frac_cnt_next = (frac_cnt_reg == 8'hFF) ? frac_cnt_reg
                                                                    : frac_cnt_reg + 8'd1;
                            tlen_next     = len_inc;
                        end
                        else
                            do_close = 1'b1;
                    end
                    M_STR:
                    begin
                        if (ch == CH_QUOTE)
                        begin
                            res0.kind   = KIND_STRING;
                            res0.start  = tstart_reg;
                            res0.length = tlen_reg;
                            res0.last   = 1'b1;
                            n_push      = 2'd1;
                            mode_next   = M_IDLE;
                        end
                        else
                            tlen_next = len_inc;
                    end
                    M_OTHER:
                    begin
                        if (!is_ws(ch))
                            tlen_next = len_inc;
                        else
                            do_close = 1'b1;
                    end
                    default: do_start = 1'b1;
                endcase

                if (do_close)
                    do_start = 1'b1;

                if (do_start)
                begin
                    mode_next     = st_mode;
                    tstart_next   = column_reg;
                    tlen_next     = 16'd1;
                    int_acc_next  = '0;
                    frac_acc_next = '0;
                    frac_cnt_next = '0;
                    if (st_mode == M_OPPEND)
                        pend_next = ch;
                    if (st_mode == M_INT)
                        int_acc_next = VALUE_BITS'(ch[3:0]);
                    if (st_mode == M_STR)
                    begin
                        tstart_next = column_reg + 16'd1;
                        tlen_next   = 16'd0;
                    end
                    // closing token first, then a one-byte token from this byte
                    if (do_close && fl_valid)
                    begin
                        res0      = fl_tok;
                        res0.last = !st_emit;
                        res1      = st_tok;
                        res1.last = 1'b1;
                        n_push    = st_emit ? 2'd2 : 2'd1;
                    end
                    else if (st_emit)
                    begin
                        res0      = st_tok;
                        res0.last = 1'b1;
                        n_push    = 2'd1;
                    end
                end
            end
        end

        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + 2'(m_fire);
        count_next  = count_reg + 3'(n_push) - 3'(m_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= M_IDLE;
            pend_reg     <= '0;
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
            column_reg   <= '0;
            tstart_reg   <= '0;
            tlen_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pend_reg     <= pend_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            frac_cnt_reg <= frac_cnt_next;
            column_reg   <= column_next;
            tstart_reg   <= tstart_next;
            tlen_reg     <= tlen_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (n_push == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    tok_t head;
    assign head         = queue_reg[rd_ptr_reg];
    assign m_axis_tdata = {head.length, head.start, head.fdig, head.frac, head.ival,
                           head.op, head.kind};
    assign m_axis_tlast = head.last;

endmodule

FILE: rtl/elu_checker.sv
// ============================================================================
// elu_checker
// Port-level checks for the expression lexer, bound to the top level.
// ============================================================================
module elu_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [elu_pkg::IN_BITS-1:0]   s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [elu_pkg::OUT_BITS-1:0]  m_axis_tdata,
    input logic                          m_axis_tlast
);
    import elu_pkg::*;

    logic       in_beat;
    logic [2:0] kind;
    logic [4:0] op;

    assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
    assign kind    = m_axis_tdata[2:0];
    assign op      = m_axis_tdata[7:3];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // input only backs up when results are waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result queue");

    // an end-of-text beat leaves the scanner idle, so the next byte closes nothing
    a_eot_tail: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid || m_axis_tlast)
        else $error("end of text left a partial token group");

    // only operators and the var marker carry an op code
    a_op_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind != KIND_OPERATOR && kind != KIND_VAR |-> op == 5'd0)
        else $error("op code set on non-operator token");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && kind == KIND_OPERATOR |-> op != OP_VAR && op != OP_ERROR
                                                   && kind != 3'd7)
        else $error("bad operator code");

endmodule

bind expression_lexer_unit elu_checker u_elu_checker (.*);

FILE: test/expression_lexer_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// expression_lexer_unit_tb
// Feeds text bytes into the lexer over the input stream and checks every
// token beat against an in-bench scanner that tracks mode, accumulators and
// column. Directed text covers each token class, value and fraction count
// saturation and a long string sent without gaps. Random token-shaped text
// with noise follows, under random source gaps and sink stalls.
// ============================================================================
module expression_lexer_unit_tb;
    import elu_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_BYTES   = 900;
    localparam logic [4:0]  NO_OP          = 5'd0;
    localparam logic [7:0]  CH_NUL         = 8'h00;
    localparam logic [63:0] VALUE_MAX      = 64'hFFFF_FFFF;

    typedef struct packed {
        logic        last;
        logic [15:0] length;
        logic [15:0] start;
        logic [7:0]  fdig;
        logic [31:0] frac;
        logic [31:0] ival;
        logic [4:0]  op;
        logic [2:0]  kind;
    } lex_token_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;

    expression_lexer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // scanner state mirrored from the text accepted so far
    mode_t       scan_mode;
    logic [7:0]  pend_op;
    logic [63:0] int_acc;
    logic [63:0] frac_acc;
    logic [7:0]  frac_cnt;
    logic [15:0] column;
    logic [15:0] tok_start;
    logic [15:0] tok_len;

    lex_token_t step_tokens[$];
    lex_token_t expected_tokens[$];

    int mismatch_count = 0;
    int bytes_sent;
    int idle_cycles;
    bit src_burst;
    bit snk_burst;

    string op_chars = "+-*/%&|~^><=(){}\\,[]?:@";

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // character classes and operator codes
    // ------------------------------------------------------------------
    function automatic bit char_is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit char_is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic op_t operator_of(input logic [7:0] c, input logic [7:0] nx,
                                        output bit found);
        found = 1'b1;
        case (c)
            "+":  return OP_PLUS;
            "-":  return OP_MINUS;
            "*":  return (nx == CH_STAR) ? OP_POW : OP_MULT;
            "/":  return OP_DIV;
            "%":  return OP_MOD;
            "&":  return OP_AND;
            "|":  return OP_OR;
            "~":  return (nx == CH_EQ) ? OP_NEQ : OP_NOT;
            "^":  return OP_XOR;
            ">":  return (nx == CH_EQ) ? OP_GTE : OP_GT;
            "<":  return (nx == CH_EQ) ? OP_LTE : OP_LT;
            "=":  return (nx == CH_EQ) ? OP_EQ : OP_ASSIGN;
            "(":  return OP_LPAREN;
            ")":  return OP_RPAREN;
            "{":  return OP_LCURL;
            "}":  return OP_RCURL;
            "\\": return OP_ESCAPE;
            ",":  return OP_COMMA;
            "[":  return OP_LBRACKET;
            "]":  return OP_RBRACKET;
            "?":  return OP_COND;
            ":":  return OP_ELSE;
            "@":  return OP_CONSTRAINT;
            default:
            begin
                found = 1'b0;
                return OP_ERROR;
            end
        endcase
    endfunction

    function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - 8'd48);
        if (acc > (VALUE_MAX - d) / 10)
            return VALUE_MAX;
        return acc * 10 + d;
    endfunction

    // ------------------------------------------------------------------
    // scanner prediction
    // ------------------------------------------------------------------
    function automatic void push_token(input logic [2:0] kind, input logic [4:0] op,
                                       input logic [63:0] iv, input logic [63:0] fv,
                                       input logic [7:0] fd, input logic [15:0] st,
                                       input logic [15:0] len);
        lex_token_t t;
        if (step_tokens.size() >= 2)
            return;
        t.kind   = kind;
        t.op     = op;
        t.ival   = iv[31:0];
        t.frac   = fv[31:0];
        t.fdig   = fd;
        t.start  = st;
        t.length = len;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void grow_length();
        if (tok_len != 16'hFFFF)
            tok_len = tok_len + 16'd1;
    endfunction

    function automatic void flush_pending();
        bit found;
        case (scan_mode)
            M_OPPEND: push_token(KIND_OPERATOR, operator_of(pend_op, CH_NUL, found),
                                 0, 0, 0, tok_start, 16'd1);
            M_SYM, M_OTHER: push_token(KIND_SYMBOL, NO_OP, 0, 0, 0, tok_start, tok_len);
            M_INT: push_token(KIND_INTEGER, NO_OP, int_acc, 0, 0, tok_start, tok_len);
            M_REAL: push_token(KIND_REAL, NO_OP, int_acc, frac_acc, frac_cnt,
                               tok_start, tok_len);
            M_STR: push_token(KIND_UNTERM, NO_OP, 0, 0, 0, tok_start, tok_len);
            default: ;
        endcase
        scan_mode = M_IDLE;
    endfunction

    function automatic void start_lexeme(input logic [7:0] c);
        bit  found;
        op_t op;
        tok_start = column;
        tok_len   = 16'd1;
        int_acc   = 0;
        frac_acc  = 0;
        frac_cnt  = 0;
        if (char_is_space(c))
            return;
        op = operator_of(c, CH_NUL, found);
        if (found)
        begin
            if (c == CH_STAR || c == CH_TILDE || c == CH_GT || c == CH_LT || c == CH_EQ)
            begin
                pend_op   = c;
                scan_mode = M_OPPEND;
            end
            else
                push_token(KIND_OPERATOR, op, 0, 0, 0, column, 16'd1);
        end
        else if (c == CH_DOLLAR)
            push_token(KIND_VAR, OP_VAR, 0, 0, 0, column, 16'd1);
        else if (char_is_letter(c))
            scan_mode = M_SYM;
        else if (char_is_digit(c))
        begin
            int_acc   = add_digit(0, c);
            scan_mode = M_INT;
        end
        else if (c == CH_QUOTE)
        begin
            tok_start = column + 16'd1;
            tok_len   = 16'd0;
            scan_mode = M_STR;
        end
        else
            scan_mode = M_OTHER;
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        bit found;
        case (scan_mode)
            M_OPPEND:
            begin
                if ((pend_op == CH_STAR && c == CH_STAR) ||
                    (pend_op != CH_STAR && c == CH_EQ))
                begin
                    push_token(KIND_OPERATOR, operator_of(pend_op, c, found),
                               0, 0, 0, tok_start, 16'd2);
                    scan_mode = M_IDLE;
                    return;
                end
            end
            M_SYM:
            begin
                if (char_is_letter(c) || c == CH_USCORE)
                begin
                    grow_length();
                    return;
                end
            end
            M_INT:
            begin
                if (char_is_digit(c))
                begin
                    int_acc = add_digit(int_acc, c);
                    grow_length();
                    return;
                end
                if (c == CH_DOT)
                begin
                    scan_mode = M_REAL;
                    grow_length();
                    return;
                end
            end
            M_REAL:
            begin
                if (char_is_digit(c))
                begin
                    frac_acc = add_digit(frac_acc, c);
                    if (frac_cnt != 8'd255)
                        frac_cnt = frac_cnt + 8'd1;
                    grow_length();
                    return;
                end
            end
            M_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    push_token(KIND_STRING, NO_OP, 0, 0, 0, tok_start, tok_len);
                    scan_mode = M_IDLE;
                end
                else
                    grow_length();
                return;
            end
            M_OTHER:
            begin
                if (!char_is_space(c))
                begin
                    grow_length();
                    return;
                end
            end
            default:
            begin
                scan_mode = M_IDLE;
                start_lexeme(c);
                return;
            end
        endcase
        flush_pending();
        start_lexeme(c);
    endfunction

    function automatic void lex_step(input logic [7:0] c, input logic eot);
        step_tokens.delete();
        if (eot)
        begin
            flush_pending();
            pend_op   = 0;
            int_acc   = 0;
            frac_acc  = 0;
            frac_cnt  = 0;
            tok_start = 0;
            tok_len   = 0;
            column    = 0;
        end
        else
        begin
            scan_byte(c);
            column = column + 16'd1;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // stream driver and token checker
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        lex_step(c, eot);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_eot();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic string token_text(input lex_token_t t);
        return $sformatf("kind=%0d op=%0d int=%0d frac=%0d fdig=%0d col=%0d len=%0d last=%0d",
                         t.kind, t.op, t.ival, t.frac, t.fdig, t.start, t.length, t.last);
    endfunction

    task automatic check_token();
        lex_token_t got;
        lex_token_t want;
        got.kind   = m_axis_tdata[2:0];
        got.op     = m_axis_tdata[7:3];
        got.ival   = m_axis_tdata[39:8];
        got.frac   = m_axis_tdata[71:40];
        got.fdig   = m_axis_tdata[79:72];
        got.start  = m_axis_tdata[95:80];
        got.length = m_axis_tdata[111:96];
        got.last   = m_axis_tlast;
        if (expected_tokens.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected token beat: %s", token_text(got));
            mismatch_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            if (got != want)
            begin
                if (mismatch_count < 10)
                    $display("token mismatch\n  expected %s\n  actual   %s",
                             token_text(want), token_text(got));
                mismatch_count++;
            end
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            int gap;
            gap = snk_burst ? 0 : $urandom_range(0, 16);
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
            check_token();
        end
    end

    // end the run after a long stretch with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("expression_lexer_unit_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // random text pieces
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(65 + r) : 8'(97 + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(48 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_space();
        return ($urandom_range(0, 2) == 0) ? 8'(32) : 8'($urandom_range(9, 13));
    endfunction

    // byte that starts a catch-all symbol
    function automatic logic [7:0] rand_stray();
        logic [7:0] c;
        bit         found;
        op_t        op;
        do
        begin
            c  = 8'($urandom_range(0, 255));
            op = operator_of(c, CH_NUL, found);
        end
        while (found || char_is_space(c) || char_is_letter(c) || char_is_digit(c) ||
               c == CH_DOLLAR || c == CH_QUOTE);
        return c;
    endfunction

    task automatic send_random_lexeme();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            send_byte(rand_letter(), 1'b0);
            n = $urandom_range(0, 7);
            repeat (n) send_byte(($urandom_range(0, 4) == 0) ? CH_USCORE : rand_letter(), 1'b0);
        end
        else if (pick < 26)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
            repeat (n) send_byte(rand_digit(), 1'b0);
        end
        else if (pick < 36)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(rand_digit(), 1'b0);
            send_byte(CH_DOT, 1'b0);
            n = ($urandom_range(0, 7) == 0) ? 12 : $urandom_range(0, 5);
            repeat (n) send_byte(rand_digit(), 1'b0);
        end
        else if (pick < 58)
        begin
            send_byte(op_chars[$urandom_range(0, op_chars.len() - 1)], 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_byte($urandom_range(0, 1) ? CH_EQ : CH_STAR, 1'b0);
        end
        else if (pick < 63)
            send_byte(CH_DOLLAR, 1'b0);
        else if (pick < 71)
        begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE);
                send_byte(c, 1'b0);
            end
            // leave some strings open so later text runs into them
            if ($urandom_range(0, 7) != 0)
                send_byte(CH_QUOTE, 1'b0);
        end
        else if (pick < 77)
        begin
            send_byte(rand_stray(), 1'b0);
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (char_is_space(c));
                send_byte(c, 1'b0);
            end
        end
        else if (pick < 85)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(rand_space(), 1'b0);
        end
        else if (pick < 95)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        else
            send_eot();
        if ($urandom_range(0, 1) == 0)
            send_byte(rand_space(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_text();
        // symbol then marker in one beat, real then operator in one beat, power pair
        send_text("Zz_q$7.+2**~=>");
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(" \"a b\"$=\t<");
        send_eot();
        send_text("\"ab");
        send_eot();
        // end of text with nothing pending
        send_eot();
    endtask

    task automatic test_value_limits();
        send_text("4294967295 4294967296 99999999999 1.99999999999 5.");
        send_eot();
        send_text("0.");
        repeat (300) send_byte(rand_digit(), 1'b0);
        send_eot();
    endtask

    task automatic test_long_string();
        src_burst = 1'b1;
        snk_burst = 1'b1;
        send_byte(CH_QUOTE, 1'b0);
        // long string streamed with no gaps on either side
        repeat (120) send_byte(rand_letter(), 1'b0);
        send_text("\" x y");
        send_eot();
        src_burst = 1'b0;
        snk_burst = 1'b0;
    endtask

    task automatic test_random_text();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                src_burst = !src_burst;
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
            send_random_lexeme();
        end
        send_eot();
        src_burst = 1'b0;
        snk_burst = 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'd0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        bytes_sent     = 0;
        src_burst      = 1'b0;
        snk_burst      = 1'b0;
        scan_mode      = M_IDLE;
        pend_op        = 0;
        int_acc        = 0;
        frac_acc       = 0;
        frac_cnt       = 0;
        column         = 0;
        tok_start      = 0;
        tok_len        = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_text();
        test_value_limits();
        test_long_string();
        test_random_text();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("expression_lexer_unit_tb passed");
        else
            $display("expression_lexer_unit_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/elu_pkg.sv
rtl/expression_lexer_unit.sv
rtl/elu_checker.sv
test/expression_lexer_unit_tb.sv
